### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, payload types and helpers for the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int TAB_WIDTH    = 4;
  localparam int CELL_COUNT   = ROWS * COLUMNS;
  localparam int SCROLL_COUNT = (ROWS - 1) * COLUMNS;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int CMD_W  = 2;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST      = 8'h7F;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_line;
    logic [ADDR_W-1:0] cursor_location;
    logic [CELL_W-1:0] cell_value;
  } out_item_t;

  // one write request into the cell store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  // outcome of interpreting one put byte
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             store;
    logic             scroll;
  } cur_upd_t;

  function automatic logic [CELL_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
    return {attr, CH_SPACE};
  endfunction

endpackage

`default_nettype wire

### src/text_console_character_writer.sv
// ----------------------------------------------------------------------------
// text_console_character_writer
// text console over an 80x25 cell store with put, clear and read commands
// ----------------------------------------------------------------------------
// usage
//   in channel: one command transaction (put byte, clear screen, read cell)
//   out channel: one result transaction per command with the cursor column,
//     row, linear location and, for a read, the addressed cell
//   cfg port: cfg_wr_en/cfg_wr_data load the attribute byte at once
// steps from the accepting edge to out_valid
//   put without scroll, other codes: EXEC then RESP; read: EXEC, RDWAIT, RESP
//   put that scrolls: one copied cell per cycle through the single memory
//     read port, then blanking of the bottom row
//   clear: one blanked cell per cycle
// one command at a time; in_ready is high only in idle
// reset: a clearing pass blanks every cell with attribute 15,
//   in_ready stays low until it ends; cursor homes, attribute returns to 15
// receiver stall: the finished result waits in the output register, and the
//   next command is still accepted and worked on; its result waits until
//   the previous transaction has been taken
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_writer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire tcw_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tcw_pkg::out_item_t              out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data
);
  import tcw_pkg::*;

  // sequencer states
  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_RDWAIT = 8'b0000_1000,
    S_CLEAR  = 8'b0001_0000,
    S_COPY   = 8'b0010_0000,
    S_BLANK  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(SCROLL_COUNT);
  localparam logic [ADDR_W-1:0] CELLS      = ADDR_W'(CELL_COUNT);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  state_t            state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;         // shared sweep address counter
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [CELL_W-1:0] cell_val, cell_val_next;
  logic [ATTR_W-1:0] attr;
  in_item_t          item;                  // command being worked on

  logic [ADDR_W-1:0] loc;
  logic              index_ok;
  logic              resp_load;
  cur_upd_t          upd;
  mem_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  tcw_cursor u_cursor (
    .col       (col),
    .row       (row),
    .char_code (item.char_code),
    .upd       (upd)
  );

  tcw_cell_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // linear cursor position
  assign loc       = ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
  assign index_ok  = item.cell_index < CELLS;
  assign in_ready  = (state == S_IDLE);
  assign resp_load = (state == S_RESP) && (!out_valid || out_ready);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    col_next      = col;
    row_next      = row;
    cell_val_next = cell_val;
    wr            = '0;
    rd_addr       = '0;
    case (state)
      S_INIT: begin
        // power-up blanking uses the reset attribute
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = blank_cell(ATTR_RESET);
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cell_val_next = '0;
        cnt_next      = '0;
        state_next    = S_RESP;
        case (item.command)
          CMD_PUT: begin
            wr.en    = upd.store;
            wr.addr  = loc;
            wr.data  = {attr, item.char_code};
            col_next = upd.col;
            row_next = upd.row;
            if (upd.scroll) begin
              state_next = S_COPY;
            end
          end
          CMD_CLEAR: begin
            col_next   = '0;
            row_next   = '0;
            state_next = S_CLEAR;
          end
          CMD_READ: begin
            rd_addr    = index_ok ? item.cell_index : '0;
            state_next = S_RDWAIT;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_RDWAIT: begin
        cell_val_next = index_ok ? rd_data : '0;
        state_next    = S_RESP;
      end
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = blank_cell(attr);
        if (cnt == LAST_CELL) begin
          state_next = S_RESP;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      S_COPY: begin
        // read one row below, write back the cell from the previous read
        if (cnt < COPY_END) begin
          rd_addr = cnt + ROW_STRIDE;
        end
        if (cnt != '0) begin
          wr.en   = 1'b1;
          wr.addr = cnt - ADDR_W'(1);
          wr.data = rd_data;
        end
        if (cnt == COPY_END) begin
          state_next = S_BLANK;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      S_BLANK: begin
        // bottom row
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = blank_cell(attr);
        if (cnt == LAST_CELL) begin
          state_next = S_RESP;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr <= cfg_wr_data;
    end
  end

  // command capture and read result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    cell_val <= cell_val_next;
  end

  // output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_data.cursor_col      <= col;
      out_data.cursor_line     <= row;
      out_data.cursor_location <= loc;
      out_data.cell_value      <= cell_val;
    end
  end

endmodule

`default_nettype wire

### src/tcw_cell_store.sv
// ----------------------------------------------------------------------------
// tcw_cell_store
// screen cell memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_store (
  input  wire logic                          clk,
  input  wire tcw_pkg::mem_wr_t              wr,
  input  wire logic [tcw_pkg::ADDR_W-1:0]    rd_addr,
  output logic      [tcw_pkg::CELL_W-1:0]    rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// cursor update for one put byte: control codes, wrap and scroll detect
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor (
  input  wire logic [tcw_pkg::COL_W-1:0]  col,
  input  wire logic [tcw_pkg::ROW_W-1:0]  row,
  input  wire logic [tcw_pkg::CHAR_W-1:0] char_code,
  output tcw_pkg::cur_upd_t               upd
);
  import tcw_pkg::*;

  localparam logic [COL_W-1:0] TAB_MASK = ~COL_W'(TAB_WIDTH - 1);

  logic [COL_W-1:0] col_n;
  logic [ROW_W-1:0] row_n;
  logic             store;

  always_comb begin
    col_n = col;
    row_n = row;
    store = 1'b0;
    case (char_code)
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_n = col - COL_W'(1);
        end
      end
      CH_TAB: begin
        col_n = (col & TAB_MASK) + COL_W'(TAB_WIDTH);
      end
      CH_CR: begin
        col_n = '0;
      end
      CH_LF: begin
        col_n = '0;
        row_n = row + ROW_W'(1);
      end
      default: begin
        if (char_code >= CH_SPACE && char_code <= CH_LAST) begin
          store = 1'b1;
          col_n = col + COL_W'(1);
        end
      end
    endcase

    // wrap past the last column
    if (col_n >= COL_W'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + ROW_W'(1);
    end

    upd.store  = store;
    upd.col    = col_n;
    upd.scroll = 1'b0;
    upd.row    = row_n;
    // past the last row: stay on it and scroll
    if (row_n >= ROW_W'(ROWS)) begin
      upd.scroll = 1'b1;
      upd.row    = ROW_W'(ROWS - 1);
    end
  end

endmodule

`default_nettype wire

### test/tb_text_console_character_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_character_writer
// self-checking bench for the text console writer: put, clear and read
// commands go in through a queued driver, and every result transaction is
// compared field by field with a behavioural copy of the console (cursor
// and full cell store). A few directed commands come first, then six random
// phases, each under its own colour attribute, with random idling on both
// sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_character_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // command code 3 has no meaning: nothing changes, the cursor is reported
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;

  // items in each random phase, six phases
  localparam int PHASE_ITEMS = 250;
  localparam int PHASE_COUNT = 6;
  // receiver stops taking results for this long once, after this many results
  localparam int HOLD_AT_RESULT = 100;
  localparam int HOLD_CYCLES    = 3000;
  // slowest correct run: every transaction a full-screen pass plus both
  // sides idling their longest, plus the clearing pass after reset,
  // taken about five times
  localparam int CYCLE_LIMIT = 16_000_000;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data = '0;

  text_console_character_writer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // behavioural console: own copy of the screen, cursor and attribute
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_copy [CELL_COUNT];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] text_attr;

  // commands waiting for the driver, and cursor reports still owed by the block
  in_item_t  queued_commands [$];
  out_item_t pending_reports [$];

  int mismatch_count = 0;

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = {text_attr, CH_SPACE};
  endfunction

  // applies one command to the copy and returns the report the block owes
  function automatic out_item_t apply_console_command(input in_item_t cmd);
    out_item_t   rep;
    int unsigned cell_pos;
    rep = '0;
    case (cmd.command)
      CMD_PUT: begin
        if (cmd.char_code == CH_BACKSPACE) begin
          // backspace at column zero stays put
          if (cur_col > 0) cur_col--;
        end else if (cmd.char_code == CH_TAB) begin
          cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
        end else if (cmd.char_code == CH_CR) begin
          cur_col = 0;
        end else if (cmd.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (cmd.char_code >= CH_SPACE && cmd.char_code <= CH_LAST) begin
          cell_pos = cur_row * COLUMNS + cur_col;
          if (cell_pos < CELL_COUNT) screen_copy[cell_pos] = {text_attr, cmd.char_code};
          cur_col++;
        end
        // other control bytes and bytes from 0x80 up are ignored
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // past the last row: shift everything up, blank the bottom row
        if (cur_row >= ROWS) begin
          for (int i = 0; i < SCROLL_COUNT; i++) screen_copy[i] = screen_copy[i + COLUMNS];
          for (int i = SCROLL_COUNT; i < CELL_COUNT; i++) screen_copy[i] = {text_attr, CH_SPACE};
          cur_row = ROWS - 1;
        end
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        // reads beyond the last cell return zero
        if (cmd.cell_index < CELL_COUNT) rep.cell_value = screen_copy[cmd.cell_index];
      end
      default: ;
    endcase
    rep.cursor_col      = COL_W'(cur_col);
    rep.cursor_line     = ROW_W'(cur_row);
    rep.cursor_location = ADDR_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued commands with a random gap between them,
  // with occasional bursts of back-to-back transactions
  // ---------------------------------------------------------------------------
  int tx_wait  = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      // accepted transaction: work out what the block must report for it
      if (in_valid && in_ready) pending_reports.push_back(apply_console_command(in_data));
      // the slot is free unless a transaction is still being offered
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else if (queued_commands.size() > 0) begin
          in_data  <= queued_commands.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
          tx_wait = tx_burst ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes results with its own random stalls and checks them
  // ---------------------------------------------------------------------------
  int rx_wait       = 0;
  bit rx_burst      = 1'b0;
  int results_taken = 0;

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_col", 32'(want.cursor_col), 32'(out_data.cursor_col));
          check_field("cursor_line", 32'(want.cursor_line), 32'(out_data.cursor_line));
          check_field("cursor_location", 32'(want.cursor_location),
                      32'(out_data.cursor_location));
          check_field("cell_value", 32'(want.cell_value), 32'(out_data.cell_value));
        end
        results_taken++;
        // one long hold-off so the block fills up and stops taking commands
        if (results_taken == HOLD_AT_RESULT) begin
          rx_wait = HOLD_CYCLES;
        end else begin
          if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
          rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** text_console_character_writer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_command(input logic [CMD_W-1:0] command, input logic [CHAR_W-1:0] ch,
                               input logic [ADDR_W-1:0] idx);
    in_item_t item;
    item.command    = command;
    item.char_code  = ch;
    item.cell_index = idx;
    queued_commands.push_back(item);
  endtask

  // the sender holds back until every queued command has been taken
  // and every owed report has arrived
  task automatic wait_until_drained();
    do @(posedge clk);
    while (queued_commands.size() != 0 || in_valid || pending_reports.size() != 0);
  endtask

  logic [ATTR_W-1:0] phase_attr [PHASE_COUNT];

  initial begin
    int unsigned roll;
    in_item_t    item;

    // state after reset: blanks in attribute 15, cursor home
    text_attr = ATTR_RESET;
    cur_col   = 0;
    cur_row   = 0;
    blank_screen();

    // extremes and a few in-between attributes, two of them random
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = ATTR_W'($urandom_range(0, 255));
    phase_attr[3] = 8'h1E;
    phase_attr[4] = ATTR_W'($urandom_range(0, 255));
    phase_attr[5] = 8'h70;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset attribute
    queue_command(CMD_READ, 8'h00, 11'd0);              // first cell, blank after reset
    queue_command(CMD_READ, 8'hFF, ADDR_W'(CELL_COUNT - 1));
    queue_command(CMD_READ, 8'h00, ADDR_W'(CELL_COUNT)); // just past the store
    queue_command(CMD_READ, 8'h00, 11'h7FF);            // largest index
    queue_command(CMD_PUT,  CH_A,      11'h7FF);
    queue_command(CMD_PUT,  CH_SPACE,  11'd0);          // lowest printable
    queue_command(CMD_PUT,  CH_LAST,   11'd0);          // highest printable
    queue_command(CMD_PUT,  8'h00,     11'd0);          // ignored control byte
    queue_command(CMD_PUT,  8'h80,     11'd0);          // ignored high bytes
    queue_command(CMD_PUT,  8'hFF,     11'd0);
    queue_command(CMD_PUT,  CH_BACKSPACE, 11'd0);
    queue_command(CMD_PUT,  CH_CR,     11'd0);
    queue_command(CMD_PUT,  CH_BACKSPACE, 11'd0);       // backspace at column zero
    queue_command(CMD_PUT,  CH_TAB,    11'd0);
    queue_command(CMD_PUT,  CH_TAB,    11'd0);
    queue_command(CMD_PUT,  CH_LF,     11'd0);
    queue_command(CMD_UNUSED, 8'hFF,   11'h7FF);
    queue_command(CMD_READ, 8'h00,     11'd0);
    queue_command(CMD_READ, 8'h00,     11'd2);
    queue_command(CMD_CLEAR, 8'hFF,    11'h7FF);
    queue_command(CMD_READ, 8'h00,     11'd0);
    wait_until_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // block is idle here: load the attribute for this phase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_attr[p];
      text_attr = phase_attr[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;

      // mostly printable text with line control, some reads, rare clears;
      // fields that the command ignores are random too
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll            = $urandom_range(0, 999);
        item.command    = CMD_PUT;
        item.char_code  = CHAR_W'($urandom_range(0, 255));
        item.cell_index = ADDR_W'($urandom_range(0, 2047));
        if (roll < 560) begin
          item.char_code = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
        end else if (roll < 640) begin
          item.char_code = CH_LF;
        end else if (roll < 670) begin
          item.char_code = CH_CR;
        end else if (roll < 710) begin
          item.char_code = CH_BACKSPACE;
        end else if (roll < 760) begin
          item.char_code = CH_TAB;
        end else if (roll < 800) begin
          // any byte at all, control and high bytes included
        end else if (roll < 802) begin
          item.command = CMD_CLEAR;
        end else if (roll < 830) begin
          item.command = CMD_UNUSED;
        end else begin
          item.command = CMD_READ;
          if ($urandom_range(0, 9) != 0)
            item.cell_index = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
        end
        queued_commands.push_back(item);
      end
      wait_until_drained();
    end

    // nothing in flight any more; allow a read's latency for stray results
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** text_console_character_writer: PASSED **");
    end else begin
      $display("** text_console_character_writer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/tcw_pkg.sv
src/tcw_cell_store.sv
src/tcw_cursor.sv
src/text_console_character_writer.sv
test/tb_text_console_character_writer.sv
